FILE: hw/rtl/cfq_pkg.sv
// cfq_pkg: shared types and constants for the circular fifo queue
// used by the controller, datapath, top level and checker; no dependencies
package cfq_pkg;

  localparam int WORD_W = 32;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic load_pop;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

FILE: hw/rtl/cfq_ram.sv
// cfq_ram: generic single-write, single-read ram with registered read data
// no package dependencies
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/cfq_ctrl.sv
// cfq_ctrl: request sequencer for the circular fifo queue
// depends on cfq_pkg; drives commands to cfq_datapath
module cfq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  cfq_pkg::req_t      req_type,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  cfq_pkg::dp_stat_t  dp_stat,
  output cfq_pkg::ctrl_cmd_t cmd
);
  import cfq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.load_pop = 1'b0;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // a successful dequeue or peek goes through S_READ to wait for the ram
          if ((req_type == REQ_DEQ || req_type == REQ_PEEK) && !dp_stat.empty) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_READ: begin
        cmd.load_pop = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/cfq_datapath.sv
// cfq_datapath: head/tail pointers, slot memory and result registers
// depends on cfq_pkg and cfq_ram; commanded by cfq_ctrl
module cfq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfq_pkg::ctrl_cmd_t                cmd,
  output cfq_pkg::dp_stat_t                 dp_stat,
  input  cfq_pkg::req_t                     req_type,
  input  logic signed [cfq_pkg::WORD_W-1:0] push_value,
  output cfq_pkg::status_t                  status,
  output logic signed [cfq_pkg::WORD_W-1:0] pop_value,
  output logic [cfq_pkg::OCC_W-1:0]         occupancy,
  output logic                              is_empty
);
  import cfq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int FW = (PW + 1 > OCC_W) ? PW + 1 : OCC_W;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [PW-1:0]     head_r, head_nxt;
  logic [PW-1:0]     tail_r, tail_nxt;
  status_t           status_r, status_nxt;
  logic [WORD_W-1:0] pop_r;
  logic [WORD_W-1:0] rd_data;
  logic [PW-1:0]     tail_inc, head_inc;
  logic              wr_en;
  logic [FW-1:0]     fill;

  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + PW'(1);
  assign head_inc = (head_r == LAST) ? '0 : head_r + PW'(1);

  assign dp_stat.empty = (head_r == tail_r);
  assign dp_stat.full  = (tail_inc == head_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    unique case (req_type) inside
      REQ_ENQ: begin
        if (dp_stat.full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en    = 1'b1;
          tail_nxt = tail_inc;
        end
      end
      REQ_DEQ, REQ_PEEK: begin
        if (dp_stat.empty) begin
          status_nxt = ST_EMPTY;
        end else if (req_type == REQ_DEQ) begin
          head_nxt = head_inc;
        end
      end
      default: begin
        head_nxt = '0;
        tail_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else if (cmd.accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r <= status_nxt;
      pop_r    <= '0;
    end else if (cmd.load_pop) begin
      pop_r <= rd_data;
    end
  end

  // read port always follows the head, so the word is ready in the cycle after accept
  cfq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.accept && wr_en),
    .waddr(tail_r),
    .wdata(push_value),
    .raddr(head_r),
    .rdata(rd_data)
  );

  assign fill = (tail_r >= head_r) ? FW'(tail_r) - FW'(head_r)
                                   : FW'(tail_r) + FW'(DEPTH) - FW'(head_r);

  assign status    = status_r;
  assign pop_value = pop_r;
  assign occupancy = fill[OCC_W-1:0];
  assign is_empty  = dp_stat.empty;

endmodule

FILE: hw/rtl/circular_fifo_queue_top.sv
// Circular FIFO of signed 32-bit words holding up to DEPTH-1 entries, one
// slot always left free. Each transaction is an enqueue, dequeue, peek or
// clear and yields exactly one result with status, popped word (zero unless
// a dequeue or peek succeeds), occupancy and empty flag. Only one transaction
// is in flight. An enqueue, a clear or any failed request offers its result
// in the cycle after accept. A successful dequeue or peek first passes
// through a read state, because the slot memory has a registered read port.
// The next transaction is taken in the cycle after the result leaves.
// Depends on cfq_pkg, cfq_ctrl, cfq_datapath and cfq_ram.
module circular_fifo_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cfq_pkg::REQ_W-1:0]         in_req_type,
  input  logic signed [cfq_pkg::WORD_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cfq_pkg::STAT_W-1:0]        out_status,
  output logic signed [cfq_pkg::WORD_W-1:0] out_pop_value,
  output logic [cfq_pkg::OCC_W-1:0]         out_occupancy,
  output logic                              out_is_empty
);
  import cfq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  dp_stat;
  req_t      req_type;
  status_t   status;

  assign req_type   = req_t'(in_req_type);
  assign out_status = status;

  cfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dp_stat  (dp_stat),
    .cmd      (cmd)
  );

  cfq_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .dp_stat   (dp_stat),
    .req_type  (req_type),
    .push_value(in_push_value),
    .status    (status),
    .pop_value (out_pop_value),
    .occupancy (out_occupancy),
    .is_empty  (out_is_empty)
  );

endmodule

FILE: hw/rtl/cfq_checker.sv
// cfq_checker: port-level assertions for circular_fifo_queue_top, bound below
// depends on cfq_pkg
module cfq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [cfq_pkg::STAT_W-1:0]        out_status,
  input logic signed [cfq_pkg::WORD_W-1:0] out_pop_value,
  input logic [cfq_pkg::OCC_W-1:0]         out_occupancy,
  input logic                              out_is_empty
);
  import cfq_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pop_value) && $stable(out_status))
    else $error("stalled result changed");

  // one transaction in flight: no accept while a result is pending
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_occupancy == '0)
    else $error("empty queue reports nonzero occupancy");

  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_is_empty && out_pop_value == '0)
    else $error("empty error with data or nonempty queue");

  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> !out_is_empty && out_pop_value == '0)
    else $error("full error on empty queue or with data");

endmodule

bind circular_fifo_queue_top cfq_checker u_cfq_checker (.*);

FILE: test/circular_fifo_queue_checker.sv
`timescale 1ns / 100ps
// circular_fifo_queue_checker: watches the request and result channels of the fifo,
// keeps its own copy of the queue to predict each result and compares field by field
// depends on cfq_pkg for the request and status codes
module circular_fifo_queue_checker #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [cfq_pkg::REQ_W-1:0]         in_req_type,
  input  logic signed [cfq_pkg::WORD_W-1:0] in_push_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [cfq_pkg::STAT_W-1:0]        out_status,
  input  logic signed [cfq_pkg::WORD_W-1:0] out_pop_value,
  input  logic [cfq_pkg::OCC_W-1:0]         out_occupancy,
  input  logic                              out_is_empty,
  output int unsigned                       error_count,
  output int unsigned                       pending_count,
  output int unsigned                       results_seen,
  output int unsigned                       full_rejects,
  output int unsigned                       empty_rejects
);
  import cfq_pkg::*;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  pop_value;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;
  } fifo_result_t;

  logic [WORD_W-1:0] slot_mem [DEPTH];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  fifo_result_t      results_due [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
    results_seen  = 0;
    full_rejects  = 0;
    empty_rejects = 0;
    rd_ptr        = 0;
    wr_ptr        = 0;
  end

  // advances the shadow queue by one request and returns what the block must answer
  function automatic fifo_result_t fifo_apply(req_t req, logic [WORD_W-1:0] word);
    fifo_result_t res;
    int unsigned  nxt;
    res.status    = ST_OK;
    res.pop_value = '0;
    case (req)
      REQ_ENQ: begin
        nxt = (wr_ptr + 1 == DEPTH) ? 0 : wr_ptr + 1;
        if (nxt == rd_ptr) begin
          res.status = ST_FULL;
        end else begin
          slot_mem[wr_ptr] = word;
          wr_ptr = nxt;
        end
      end
      REQ_DEQ, REQ_PEEK: begin
        if (rd_ptr == wr_ptr) begin
          res.status = ST_EMPTY;
        end else begin
          res.pop_value = slot_mem[rd_ptr];
          if (req == REQ_DEQ) rd_ptr = (rd_ptr + 1 == DEPTH) ? 0 : rd_ptr + 1;
        end
      end
      default: begin
        rd_ptr = 0;
        wr_ptr = 0;
      end
    endcase
    res.occupancy = OCC_W'((wr_ptr + DEPTH - rd_ptr) % DEPTH);
    res.is_empty  = (rd_ptr == wr_ptr);
    return res;
  endfunction

  always @(posedge clk) begin
    fifo_result_t exp_res;
    if (!rst_n) begin
      rd_ptr = 0;
      wr_ptr = 0;
      results_due.delete();
    end else begin
      // results first: a result never belongs to the request taken at the same edge
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("unexpected result: status %0d pop_value %0d occupancy %0d",
                 out_status, out_pop_value, out_occupancy);
          error_count++;
        end else begin
          exp_res = results_due.pop_front();
          if (out_status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_status);
            error_count++;
          end
          if (out_pop_value !== exp_res.pop_value) begin
            $error("pop_value: expected %0d, got %0d", exp_res.pop_value, out_pop_value);
            error_count++;
          end
          if (out_occupancy !== exp_res.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp_res.occupancy, out_occupancy);
            error_count++;
          end
          if (out_is_empty !== exp_res.is_empty) begin
            $error("is_empty: expected %0d, got %0d", exp_res.is_empty, out_is_empty);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        exp_res = fifo_apply(req_t'(in_req_type), in_push_value);
        if (exp_res.status == ST_FULL) full_rejects++;
        if (exp_res.status == ST_EMPTY) empty_rejects++;
        results_due.push_back(exp_res);
      end
    end
    pending_count = results_due.size();
  end

endmodule

FILE: test/circular_fifo_queue_top_tb.sv
`timescale 1ns / 100ps
// circular_fifo_queue_top_tb: drives directed and random queue requests into the fifo
// with random gaps and result stalls; depends on cfq_pkg, the rtl and the checker
module circular_fifo_queue_top_tb;
  import cfq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int NUM_RANDOM  = 1850;
  localparam int CYCLE_LIMIT = 600000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [REQ_W-1:0]         in_req_type = REQ_ENQ;
  logic signed [WORD_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [WORD_W-1:0] out_pop_value;
  logic [OCC_W-1:0]         out_occupancy;
  logic                     out_is_empty;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned results_seen;
  int unsigned full_rejects;
  int unsigned empty_rejects;

  int unsigned cycle_count = 0;
  int unsigned stall_hold = 0;
  int unsigned stall_roll;

  circular_fifo_queue_top #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_pop_value (out_pop_value),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty)
  );

  circular_fifo_queue_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_pop_value (out_pop_value),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty),
    .error_count   (error_count),
    .pending_count (pending_count),
    .results_seen  (results_seen),
    .full_rejects  (full_rejects),
    .empty_rejects (empty_rejects)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure: free stretches, short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(1, 12);
      end else if (stall_roll < 90) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(1, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(8, 40);
      end
    end else begin
      stall_hold <= stall_hold - 1;
    end
  end

  // holds the transaction until the edge that takes it
  task automatic send_req(req_t req, logic [WORD_W-1:0] word);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_push_value <= word;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 32'h8000_0000;
    if (roll < 6) return 32'h7FFF_FFFF;
    if (roll < 8) return 32'h0000_0000;
    if (roll < 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  initial begin
    int unsigned seg_left;
    int unsigned mode;
    int unsigned no_gaps;
    int unsigned roll;
    int unsigned gap;
    req_t        req;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty rejects, extreme words, then fill to the one-free-slot limit
    send_req(REQ_DEQ, 32'h0);
    send_req(REQ_PEEK, 32'hFFFF_FFFF);
    send_req(REQ_ENQ, 32'h7FFF_FFFF);
    send_req(REQ_ENQ, 32'h8000_0000);
    send_req(REQ_PEEK, 32'h0);
    send_req(REQ_DEQ, 32'h0);
    send_req(REQ_DEQ, 32'h0);
    for (int i = 0; i < DEPTH - 1; i++) begin
      send_req(REQ_ENQ, (i % 2) ? 32'hFFFF_FFFF ^ (32'h1 << i) : (32'h1 << (2 * i)));
    end
    send_req(REQ_ENQ, 32'h5A5A_A5A5);
    send_req(REQ_PEEK, 32'h0);
    send_req(REQ_CLEAR, 32'h0);

    seg_left = 0;
    mode     = 0;
    no_gaps  = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        mode     = $urandom_range(0, 2);
        no_gaps  = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      // fill-heavy, drain-heavy and mixed stretches to hit full and empty often
      case (mode)
        0: req = req_t'((roll < 75) ? REQ_ENQ : (roll < 90) ? REQ_DEQ :
                        (roll < 98) ? REQ_PEEK : REQ_CLEAR);
        1: req = req_t'((roll < 15) ? REQ_ENQ : (roll < 85) ? REQ_DEQ :
                        (roll < 98) ? REQ_PEEK : REQ_CLEAR);
        default: req = req_t'((roll < 40) ? REQ_ENQ : (roll < 75) ? REQ_DEQ :
                              (roll < 95) ? REQ_PEEK : REQ_CLEAR);
      endcase
      send_req(req, pick_word());
      gap  = 0;
      roll = $urandom_range(0, 99);
      if (!no_gaps) begin
        if (roll >= 92) gap = $urandom_range(10, 30);
        else if (roll >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("checked %0d results over directed and random request mixes", results_seen);
    $display("%0d enqueues refused on a full queue, %0d reads refused on an empty one",
             full_rejects, empty_rejects);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
